// ===== sv/mms_pkg.sv =====
// Shared types, constants and helpers of the min-max scaler.
package mms_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned WIDE_W = 49;   // width of the divider dividend and of wide sums
  localparam int unsigned PROD_W = 64;
  localparam int unsigned STEP_W = 6;    // counts the divider steps

  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

  localparam logic signed [DATA_W-1:0] RANGE_LOW_RST    = 32'sh0000_0000;
  localparam logic signed [DATA_W-1:0] RANGE_HIGH_RST   = 32'sh0001_0000;
  localparam logic signed [DATA_W-1:0] EMPTY_MARKER_RST = 32'sh8000_0000;

  typedef enum logic [1:0] {
    CFG_RANGE_LOW    = 2'd0,
    CFG_RANGE_HIGH   = 2'd1,
    CFG_EMPTY_MARKER = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_index_e;

  typedef enum logic [2:0] {
    S_LOAD,
    S_SETUP,
    S_DIV,
    S_GAIN,
    S_PROD,
    S_OFFS,
    S_RD,
    S_MUL
  } state_e;

  typedef struct packed {
    logic load;       // accept one sample
    logic div_init;   // latch dividend, divisor and degenerate flag
    logic div_step;   // one restoring division step
    logic gain_set;   // saturate the quotient into the gain register
    logic mul_min;    // multiply min by gain
    logic off_set;    // form the offset, rewind the emit index
    logic rd;         // read the store at the emit index
    logic put;        // load the output register
    logic clear;      // return the block state to reset values
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
    logic last_item;
  } sts_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [DATA_W-1:0] sat_s32(input logic signed [WIDE_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v[WIDE_W-1:DATA_W-1] == '0 || v[WIDE_W-1:DATA_W-1] == '1) begin
      r = v[DATA_W-1:0];
    end else if (v[WIDE_W-1]) begin
      r = S32_MIN;
    end else begin
      r = S32_MAX;
    end
    return r;
  endfunction

endpackage

// ===== sv/mms_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mms_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/mms_ctrl.sv =====
// Sequencer of the min-max scaler: load, divide, offset and emit phases.
module mms_ctrl import mms_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic last_in_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (last_in_i) begin
            state_d = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        cmd_o.div_init = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_GAIN;
        end
      end
      S_GAIN: begin
        cmd_o.gain_set = 1'b1;
        state_d        = S_PROD;
      end
      S_PROD: begin
        cmd_o.mul_min = 1'b1;
        state_d       = S_OFFS;
      end
      S_OFFS: begin
        cmd_o.off_set = 1'b1;
        state_d       = S_RD;
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_MUL;
      end
      S_MUL: begin
        // hold the product until the output register frees up
        if (sts_i.out_free) begin
          cmd_o.put = 1'b1;
          if (sts_i.last_item) begin
            cmd_o.clear = 1'b1;
            state_d     = S_LOAD;
          end else begin
            state_d = S_RD;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

endmodule

// ===== sv/mms_dp.sv =====
// Datapath of the min-max scaler: registers, store, extrema, divider, multiplier, output.
module mms_dp import mms_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  output sts_t                     sts_o,
  input  logic                     cfg_we_i,
  input  cfg_index_e               cfg_index_i,
  input  logic signed [DATA_W-1:0] cfg_data_i,
  input  logic signed [DATA_W-1:0] sample_i,
  input  logic                     out_stall_i,
  output logic                     out_valid_o,
  output logic signed [DATA_W-1:0] scaled_value_o,
  output logic signed [DATA_W-1:0] gain_o,
  output logic signed [DATA_W-1:0] offset_o,
  output logic                     degenerate_o,
  output logic                     last_out_o
);

  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned AW = $clog2(MAX_ITEMS);

  logic signed [DATA_W-1:0] range_low_q, range_high_q, empty_marker_q;
  logic signed [DATA_W-1:0] min_q, max_q;
  logic                     any_q;
  logic [CW-1:0]            count_q, idx_q;
  logic                     full;
  logic                     store_we;
  logic [DATA_W-1:0]        rdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q    <= RANGE_LOW_RST;
      range_high_q   <= RANGE_HIGH_RST;
      empty_marker_q <= EMPTY_MARKER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_RANGE_LOW:    range_low_q    <= cfg_data_i;
        CFG_RANGE_HIGH:   range_high_q   <= cfg_data_i;
        CFG_EMPTY_MARKER: empty_marker_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign full     = (count_q == CW'(MAX_ITEMS));
  assign store_we = cmd_i.load && !full;

  // block state: fill count and running extrema
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      min_q   <= S32_MAX;
      max_q   <= S32_MIN;
      any_q   <= 1'b0;
    end else if (cmd_i.clear) begin
      count_q <= '0;
      min_q   <= S32_MAX;
      max_q   <= S32_MIN;
      any_q   <= 1'b0;
    end else if (store_we) begin
      count_q <= count_q + CW'(1);
      if (sample_i != empty_marker_q) begin
        any_q <= 1'b1;
        if (sample_i < min_q) min_q <= sample_i;
        if (sample_i > max_q) max_q <= sample_i;
      end
    end
  end

  mms_ram #(
    .WIDTH(DATA_W),
    .DEPTH(MAX_ITEMS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (store_we),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i(sample_i),
    .re_i   (cmd_i.rd),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(rdata)
  );

  // restoring divider on magnitudes, one quotient bit per cycle
  logic signed [DATA_W:0] num, den;
  logic [DATA_W:0]        num_mag;
  logic [WIDE_W-1:0]      dvd_q;
  logic [DATA_W-1:0]      rem_q;
  logic [DATA_W:0]        trial;
  logic [DATA_W-1:0]      den_q;
  logic                   neg_q, degen_q, ge;
  logic [STEP_W-1:0]      step_q;

  assign num     = {range_high_q[DATA_W-1], range_high_q} - {range_low_q[DATA_W-1], range_low_q};
  assign den     = {max_q[DATA_W-1], max_q} - {min_q[DATA_W-1], min_q};
  assign num_mag = num[DATA_W] ? (DATA_W+1)'(-num) : num;
  assign trial   = {rem_q, dvd_q[WIDE_W-1]};
  assign ge      = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      dvd_q   <= {num_mag, 16'b0};
      rem_q   <= '0;
      den_q   <= den[DATA_W-1:0];
      neg_q   <= num[DATA_W];
      degen_q <= !any_q || (max_q == min_q);
      step_q  <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= ge ? DATA_W'(trial - {1'b0, den_q}) : trial[DATA_W-1:0];
      dvd_q  <= {dvd_q[WIDE_W-2:0], ge};
      step_q <= step_q + STEP_W'(1);
    end
  end

  // gain, min product and offset
  logic signed [DATA_W-1:0] gain_q, offset_q, gain_sat, v_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [WIDE_W-1:0] prod_floor, off_wide;

  always_comb begin
    if (neg_q) begin
      gain_sat = (dvd_q > WIDE_W'(33'h0_8000_0000)) ? S32_MIN : DATA_W'(-dvd_q[DATA_W-1:0]);
    end else begin
      gain_sat = (dvd_q > WIDE_W'(33'h0_7fff_ffff)) ? S32_MAX : dvd_q[DATA_W-1:0];
    end
  end

  // floor division by 65536 of the product is an arithmetic shift
  assign prod_floor = {prod_q[PROD_W-1], prod_q[PROD_W-1:16]};
  assign off_wide   = WIDE_W'(range_low_q) - prod_floor;

  always_ff @(posedge clk_i) begin
    if (cmd_i.gain_set) begin
      gain_q <= degen_q ? '0 : gain_sat;
    end
    if (cmd_i.mul_min) begin
      prod_q <= min_q * gain_q;
    end
    if (cmd_i.off_set) begin
      offset_q <= degen_q ? '0 : sat_s32(off_wide);
    end
  end

  // sample product: rdata is valid the cycle after rd
  logic mul_pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_pend_q <= 1'b0;
    end else begin
      mul_pend_q <= cmd_i.rd;
    end
  end

  logic signed [PROD_W-1:0] smp_prod_q;
  logic signed [WIDE_W-1:0] smp_floor;

  always_ff @(posedge clk_i) begin
    if (mul_pend_q) begin
      smp_prod_q <= $signed(rdata) * gain_q;
      v_q        <= rdata;
    end
  end

  assign smp_floor = {smp_prod_q[PROD_W-1], smp_prod_q[PROD_W-1:16]};

  logic signed [WIDE_W-1:0] smp_wide;
  logic signed [DATA_W-1:0] smp_scaled;

  assign smp_wide   = smp_floor + WIDE_W'(offset_q);
  assign smp_scaled = (v_q == empty_marker_q) ? v_q : sat_s32(smp_wide);

  // emit index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.off_set) begin
      idx_q <= '0;
    end else if (cmd_i.put) begin
      idx_q <= idx_q + CW'(1);
    end
  end

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.put) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.put) begin
      scaled_value_o <= smp_scaled;
      gain_o         <= gain_q;
      offset_o       <= offset_q;
      degenerate_o   <= degen_q;
      last_out_o     <= sts_o.last_item;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.div_last  = (step_q == STEP_W'(WIDE_W - 1));
  // the put waits while the read is still pending (mul_pend_q) so the sample product is ready
  assign sts_o.out_free  = (!out_valid_q || !out_stall_i) && !mul_pend_q;
  assign sts_o.last_item = (idx_q == count_q - CW'(1));

endmodule

// ===== sv/min_max_scaler.sv =====
// Top level of the min-max scaler: sequencer and datapath.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------
//  input   | in        | in_valid_i / in_stall_o   | sample_i, last_in_i
//  output  | out       | out_valid_o / out_stall_i | scaled_value_o, gain_o, offset_o,
//          |           |                           | degenerate_o, last_out_o
//  config  | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// Samples load one per cycle into the store while in_stall_o is low. After the transaction
// flagged last_in, the block runs a setup step, the divider steps (one quotient bit each)
// and the gain, min*gain and offset steps. Each result then passes a store read, a multiply
// and an output load, one result at a time; a stalled output holds it back.
// Input stays stalled from the last sample until the final result is loaded for output.
// Reset sets the registers to their defaults and clears the extrema and the fill count.
module min_max_scaler import mms_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] sample_i,
  input  logic                     last_in_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] scaled_value_o,
  output logic signed [DATA_W-1:0] gain_o,
  output logic signed [DATA_W-1:0] offset_o,
  output logic                     degenerate_o,
  output logic                     last_out_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [1:0]               cfg_index_i,
  input  logic signed [DATA_W-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  mms_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .last_in_i (last_in_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  mms_dp #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_e'(cfg_index_i)),
    .cfg_data_i    (cfg_data_i),
    .sample_i      (sample_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .scaled_value_o(scaled_value_o),
    .gain_o        (gain_o),
    .offset_o      (offset_o),
    .degenerate_o  (degenerate_o),
    .last_out_o    (last_out_o)
  );

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench of the min-max scaler: directed table, then random sample blocks.
module tb;
  import mms_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned ITEM_GOAL = 480;

  typedef struct packed {
    logic signed [DATA_W-1:0] scaled;
    logic signed [DATA_W-1:0] gain;
    logic signed [DATA_W-1:0] offset;
    logic                     degen;
    logic                     last;
  } result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e                kind;
    cfg_index_e               idx;
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     typed;
    result_t                  want;
  } row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic signed [DATA_W-1:0] sample_i;
  logic                     last_in_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [DATA_W-1:0] scaled_value_o;
  logic signed [DATA_W-1:0] gain_o;
  logic signed [DATA_W-1:0] offset_o;
  logic                     degenerate_o;
  logic                     last_out_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  cfg_index_e               cfg_index_i;
  logic signed [DATA_W-1:0] cfg_data_i;

  // predictor state
  logic signed [DATA_W-1:0] shadow_store [CAPACITY];
  logic signed [DATA_W-1:0] lo_seen;
  logic signed [DATA_W-1:0] hi_seen;
  int unsigned              fill;
  logic                     have_valid;
  logic signed [DATA_W-1:0] cfg_lo;
  logic signed [DATA_W-1:0] cfg_hi;
  logic signed [DATA_W-1:0] cfg_marker;

  result_t     pending_results [$];
  row_t        plan [$];
  logic        typed_pending;
  result_t     typed_want;
  int unsigned fault_count;
  int unsigned items_sent;
  int unsigned hold_left;
  bit          calm;

  min_max_scaler #(
    .MAX_ITEMS(CAPACITY)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .sample_i,
    .last_in_i,
    .out_valid_o,
    .out_stall_i,
    .scaled_value_o,
    .gain_o,
    .offset_o,
    .degenerate_o,
    .last_out_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  function automatic logic signed [DATA_W-1:0] clamp32(input longint v);
    if (v > longint'(S32_MAX)) return S32_MAX;
    if (v < longint'(S32_MIN)) return S32_MIN;
    return v[DATA_W-1:0];
  endfunction

  function automatic void clear_block();
    lo_seen = S32_MAX;
    hi_seen = S32_MIN;
    fill = 0;
    have_valid = 1'b0;
  endfunction

  // Load one sample; on the last one, queue the scaled block.
  function automatic void load_sample(input logic signed [DATA_W-1:0] s, input logic last);
    longint  num, den, g, o;
    logic    dg;
    result_t r;
    if (fill < CAPACITY) begin
      shadow_store[fill] = s;
      fill++;
      if (s != cfg_marker) begin
        have_valid = 1'b1;
        if (s < lo_seen) lo_seen = s;
        if (s > hi_seen) hi_seen = s;
      end
    end
    if (!last) return;
    dg = !have_valid || (hi_seen == lo_seen);
    g = 0;
    o = 0;
    if (!dg) begin
      num = (longint'(cfg_hi) - longint'(cfg_lo)) * 65536;
      den = longint'(hi_seen) - longint'(lo_seen);
      g = clamp32(num / den);
      o = clamp32(longint'(cfg_lo) - ((longint'(lo_seen) * g) >>> 16));
    end
    for (int unsigned k = 0; k < fill; k++) begin
      if (shadow_store[k] == cfg_marker) r.scaled = shadow_store[k];
      else r.scaled = clamp32(((longint'(shadow_store[k]) * g) >>> 16) + o);
      r.gain = g[DATA_W-1:0];
      r.offset = o[DATA_W-1:0];
      r.degen = dg;
      r.last = (k + 1 == fill);
      pending_results.push_back(r);
    end
    // a typed row replaces the single prediction of its one-sample block
    if (typed_pending) begin
      void'(pending_results.pop_back());
      pending_results.push_back(typed_want);
    end
    clear_block();
  endfunction

  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{scaled_value_o, gain_o, offset_o, degenerate_o, last_out_o};
        hold_left = calm ? 0 : $urandom_range(0, 10);
        if (pending_results.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("unexpected result: scaled %h gain %h offset %h degen %b last %b",
                     got.scaled, got.gain, got.offset, got.degen, got.last);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            fault_count++;
            if (fault_count <= 10)
              $display("mismatch: scaled %h/%h gain %h/%h offset %h/%h degen %b/%b last %b/%b",
                       want.scaled, got.scaled, want.gain, got.gain, want.offset, got.offset,
                       want.degen, got.degen, want.last, got.last);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_RANGE_LOW:    cfg_lo = cfg_data_i;
          CFG_RANGE_HIGH:   cfg_hi = cfg_data_i;
          CFG_EMPTY_MARKER: cfg_marker = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        items_sent++;
        load_sample(sample_i, last_in_i);
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    out_stall_i <= (hold_left != 0);
    if (hold_left != 0) hold_left--;
  end

  task automatic add_row(input row_kind_e kind, input logic signed [DATA_W-1:0] value,
                         input logic last = 1'b0, input cfg_index_e idx = CFG_UNUSED,
                         input logic typed = 1'b0, input result_t want = '0);
    row_t r;
    r = '{kind, idx, value, last, typed, want};
    plan.push_back(r);
  endtask

  task automatic send_item(input logic signed [DATA_W-1:0] s, input logic last,
                           input logic typed = 1'b0, input result_t want = '0);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    // tag the transaction with its typed expectation, if any
    typed_pending = typed;
    typed_want = want;
    in_valid_i <= 1'b1;
    sample_i <= s;
    last_in_i <= last;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid and hold off until every queued result has come out.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_index_e idx, input logic signed [DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [DATA_W-1:0] draw_reg(input logic signed [DATA_W-1:0] dflt);
    case ($urandom_range(0, 4))
      0: return dflt;
      1: return S32_MIN;
      2: return S32_MAX;
      3: return $urandom;
      default: return (int'($urandom_range(0, 16)) - 8) * 65536;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_sample(input int unsigned style,
                                                           input logic signed [DATA_W-1:0] base);
    if ($urandom_range(0, 9) == 0) return cfg_marker;
    case (style)
      0: return $urandom;
      1: return base + $urandom_range(0, 1 << 18);
      default: begin
        case ($urandom_range(0, 5))
          0: return S32_MIN;
          1: return S32_MAX;
          2: return 32'sd0;
          3: return -32'sd1;
          4: return 32'sd1;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  initial begin
    int unsigned              len, style, nblocks, pick;
    logic signed [DATA_W-1:0] base;
    bit                       first;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    sample_i = '0;
    last_in_i = 1'b0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_RANGE_LOW;
    cfg_data_i = '0;
    typed_pending = 1'b0;
    typed_want = '0;
    fault_count = 0;
    items_sent = 0;
    hold_left = 0;
    calm = 1'b0;
    cfg_lo = RANGE_LOW_RST;
    cfg_hi = RANGE_HIGH_RST;
    cfg_marker = EMPTY_MARKER_RST;
    clear_block();

    // single-sample blocks after reset are degenerate, then a three-sample block
    add_row(ROW_ITEM, 32'sh0001_0000, 1'b1, CFG_UNUSED, 1'b1, '{32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b1});
    add_row(ROW_ITEM, S32_MIN, 1'b1, CFG_UNUSED, 1'b1, '{S32_MIN, 32'sd0, 32'sd0, 1'b1, 1'b1});
    add_row(ROW_ITEM, S32_MAX, 1'b1, CFG_UNUSED, 1'b1, '{32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b1});
    add_row(ROW_ITEM, 32'sd0);
    add_row(ROW_ITEM, 32'sh0002_0000);
    add_row(ROW_ITEM, -32'sh0001_0000, 1'b1);
    // widest target range, marker at zero
    add_row(ROW_CFG, S32_MIN, 1'b0, CFG_RANGE_LOW);
    add_row(ROW_CFG, S32_MAX, 1'b0, CFG_RANGE_HIGH);
    add_row(ROW_CFG, 32'sd0, 1'b0, CFG_EMPTY_MARKER);
    add_row(ROW_ITEM, S32_MIN);
    add_row(ROW_ITEM, 32'sd0);
    add_row(ROW_ITEM, S32_MAX, 1'b1);
    // unit spread saturates gain and offset
    add_row(ROW_ITEM, 32'sd1);
    add_row(ROW_ITEM, 32'sd2, 1'b1);
    // inverted range gives a negative gain
    add_row(ROW_CFG, 32'sh0005_0000, 1'b0, CFG_RANGE_LOW);
    add_row(ROW_CFG, -32'sh0005_0000, 1'b0, CFG_RANGE_HIGH);
    add_row(ROW_ITEM, -32'sd100);
    add_row(ROW_ITEM, 32'sd100);
    add_row(ROW_ITEM, 32'sd7, 1'b1);
    // marker changed while a block is loading
    add_row(ROW_ITEM, 32'sd42);
    add_row(ROW_CFG, 32'sd42, 1'b0, CFG_EMPTY_MARKER);
    add_row(ROW_ITEM, 32'sd42);
    add_row(ROW_ITEM, 32'sd10, 1'b1);
    add_row(ROW_CFG, 32'sd12345, 1'b0, CFG_UNUSED);
    add_row(ROW_CFG, RANGE_LOW_RST, 1'b0, CFG_RANGE_LOW);
    add_row(ROW_CFG, RANGE_HIGH_RST, 1'b0, CFG_RANGE_HIGH);
    add_row(ROW_CFG, EMPTY_MARKER_RST, 1'b0, CFG_EMPTY_MARKER);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        send_item(plan[i].value, plan[i].last, plan[i].typed, plan[i].want);
      end
    end

    first = 1'b1;
    while (items_sent < ITEM_GOAL) begin
      wait_idle();
      write_reg(CFG_RANGE_LOW, draw_reg(RANGE_LOW_RST));
      write_reg(CFG_RANGE_HIGH, draw_reg(RANGE_HIGH_RST));
      write_reg(CFG_EMPTY_MARKER, draw_reg(EMPTY_MARKER_RST));
      if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, $urandom);
      calm = ($urandom_range(0, 3) == 0);
      nblocks = $urandom_range(3, 8);
      for (int unsigned b = 0; b < nblocks && items_sent < ITEM_GOAL; b++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) len = $urandom_range(1, 8);
        else if (pick < 92) len = $urandom_range(9, 40);
        else if (pick < 97) len = $urandom_range(41, 64);
        else len = $urandom_range(65, 70);
        // overflow the store at least once
        if (first) len = 67;
        first = 1'b0;
        style = $urandom_range(0, 2);
        base = $urandom;
        for (int unsigned i = 0; i < len; i++)
          send_item(pick_sample(style, base), i == len - 1);
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
